// ===== hdl/rpnsc_pkg.sv =====
// Shared types and constants for the RPN stack calculator.
`default_nettype none

package rpnsc_pkg;

    localparam int DATA_W        = 32;
    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEPTH_OUT_W   = 5;

    typedef enum logic [2:0] {
        CMD_PUSH = 3'd0,
        CMD_DROP = 3'd1,
        CMD_ADD  = 3'd2,
        CMD_SUB  = 3'd3,
        CMD_MUL  = 3'd4,
        CMD_DIV  = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FEW     = 3'd1,
        ST_DIVZERO = 3'd2,
        ST_FULL    = 3'd3,
        ST_INVALID = 3'd4
    } t_status;

    // per-cell move: keep, take upper neighbor (push side), take lower neighbor (pop side)
    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_UP   = 2'd1,
        SH_DOWN = 2'd2
    } t_shift;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [DATA_W-1:0] operand;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] top_value;
        logic                     top_valid;
        logic [DEPTH_OUT_W-1:0]   stack_depth;
    } t_out_beat;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quo;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== hdl/rpnsc_cell.sv =====
// One stack cell: holds an entry and moves it toward either neighbor.
`default_nettype none

module rpnsc_cell (
    input  wire logic                         i_clk,
    input  wire rpnsc_pkg::t_shift            i_shift,
    input  wire logic [rpnsc_pkg::DATA_W-1:0] i_from_up,
    input  wire logic [rpnsc_pkg::DATA_W-1:0] i_from_down,
    output logic      [rpnsc_pkg::DATA_W-1:0] o_value
);
    import rpnsc_pkg::*;

    logic [DATA_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        case (i_shift)
            SH_UP:   r_value <= i_from_up;
            SH_DOWN: r_value <= i_from_down;
            default: r_value <= r_value;
        endcase
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

// ===== hdl/rpnsc_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
`default_nettype none

module rpnsc_div (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire rpnsc_pkg::t_div_req i_req,
    output rpnsc_pkg::t_div_rsp      o_rsp
);
    import rpnsc_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_count;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_den;

    logic [DATA_W:0]   w_rem_sh;
    logic [DATA_W:0]   w_diff;
    logic              w_bit;

    assign w_rem_sh = {r_rem, r_quo[DATA_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_den};
    assign w_bit    = !w_diff[DATA_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_count <= '0;
            end else if (r_busy) begin
                r_count <= r_count + CNT_W'(1);
                if (r_count == CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= w_bit ? w_diff[DATA_W-1:0] : w_rem_sh[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], w_bit};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

`default_nettype wire

// ===== hdl/rpn_stack_calculator_core.sv =====
// Top level of the RPN stack calculator: control, ALU and a row of stack cells.
`default_nettype none

// Reverse Polish stack calculator. Each input beat carries a command (push, drop,
// add, subtract, multiply, divide) and an operand; each accepted beat yields exactly
// one output beat with status, top value, top-valid flag and depth. The stack is a
// row of STACK_DEPTH identical cells with the top entry in cell 0: a push shifts every
// entry one cell down, a drop or a completed two-operand op shifts them up, so the
// two operands always sit in cells 0 and 1. Push, drop, add, subtract, multiply and
// every error case finish in the accept cycle: the result is registered and a new
// beat can be taken the next cycle, also while the previous result is still waiting
// as long as it is taken in that cycle. A divide runs the bit-serial divider and
// the result is registered once the divider reports done; no beat is taken from
// the accept of a divide until its result is registered. The output register holds
// one result; input ready drops while it is full and not being drained. Stack
// entries have no reset; the depth counter, state and output-valid flag do. A
// depth above 31 reports its low five bits.
module rpn_stack_calculator_core #(
    parameter int STACK_DEPTH = rpnsc_pkg::DEF_STACK_DEPTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire rpnsc_pkg::t_in_beat  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output rpnsc_pkg::t_out_beat      o_out_data
);
    import rpnsc_pkg::*;

    localparam int DW = $clog2(STACK_DEPTH + 1);

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DIV  = 1'b1
    } t_state;

    t_state            r_state, n_state;
    logic [DW-1:0]     r_depth, n_depth;
    logic              r_out_valid, n_out_valid;
    t_out_beat         r_out, n_out;
    logic              r_neg, n_neg;       // quotient sign for the running divide

    logic [DATA_W-1:0] w_cell [STACK_DEPTH];
    t_shift            w_shift0, w_shift_rest;
    logic [DATA_W-1:0] w_load;

    logic [DATA_W-1:0] w_top, w_sec;
    logic [DATA_W-1:0] w_prod;
    logic [DATA_W-1:0] w_mag_l, w_mag_r, w_quo;
    logic              w_accept;
    logic              w_full, w_has1, w_has2;
    logic [DW+DEPTH_OUT_W-1:0] w_depth_ext;

    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;

    assign w_top  = w_cell[0];
    assign w_sec  = w_cell[1];
    assign w_full = (r_depth == DW'(STACK_DEPTH));
    assign w_has1 = (r_depth != '0);
    assign w_has2 = (r_depth > DW'(1));

    // operands: second entry is left, top is right; only the low word of the product
    assign w_prod  = w_sec * w_top;
    assign w_mag_l = w_sec[DATA_W-1] ? (DATA_W'(0) - w_sec) : w_sec;
    assign w_mag_r = w_top[DATA_W-1] ? (DATA_W'(0) - w_top) : w_top;
    assign w_quo   = r_neg ? (DATA_W'(0) - w_div_rsp.quo) : w_div_rsp.quo;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state       = r_state;
        n_depth       = r_depth;
        n_neg         = r_neg;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out         = r_out;
        w_shift0      = SH_HOLD;
        w_shift_rest  = SH_HOLD;
        w_load        = i_in_data.operand;
        w_div_req.start = 1'b0;
        w_div_req.num   = w_mag_l;
        w_div_req.den   = w_mag_r;

        n_out.status    = ST_OK;
        n_out.top_value = w_has1 ? w_top : '0;

        if (w_accept) begin
            n_out_valid = 1'b1;
            case (i_in_data.command)
                CMD_PUSH: begin
                    if (w_full) begin
                        n_out.status = ST_FULL;
                    end else begin
                        w_shift0        = SH_UP;
                        w_shift_rest    = SH_UP;
                        n_depth         = r_depth + DW'(1);
                        n_out.top_value = i_in_data.operand;
                    end
                end
                CMD_DROP: begin
                    if (w_has1) begin
                        w_shift0        = SH_DOWN;
                        w_shift_rest    = SH_DOWN;
                        n_depth         = r_depth - DW'(1);
                        n_out.top_value = w_has2 ? w_sec : '0;
                    end
                end
                CMD_ADD, CMD_SUB, CMD_MUL: begin
                    if (!w_has2) begin
                        n_out.status = ST_FEW;
                    end else begin
                        case (i_in_data.command)
                            CMD_ADD: w_load = w_sec + w_top;
                            CMD_SUB: w_load = w_sec - w_top;
                            default: w_load = w_prod;
                        endcase
                        w_shift0        = SH_UP;
                        w_shift_rest    = SH_DOWN;
                        n_depth         = r_depth - DW'(1);
                        n_out.top_value = w_load;
                    end
                end
                CMD_DIV: begin
                    if (!w_has2) begin
                        n_out.status = ST_FEW;
                    end else if (w_top == '0) begin
                        n_out.status = ST_DIVZERO;
                    end else begin
                        // result beat comes when the divider finishes
                        n_out_valid     = 1'b0;
                        w_div_req.start = 1'b1;
                        n_neg           = w_sec[DATA_W-1] ^ w_top[DATA_W-1];
                        n_state         = S_DIV;
                    end
                end
                default: begin
                    n_out.status = ST_INVALID;
                end
            endcase
        end else if (r_state == S_DIV && w_div_rsp.done) begin
            w_load          = w_quo;
            w_shift0        = SH_UP;
            w_shift_rest    = SH_DOWN;
            n_depth         = r_depth - DW'(1);
            n_out_valid     = 1'b1;
            n_out.top_value = w_quo;
            n_state         = S_IDLE;
        end else begin
            n_out.status    = r_out.status;
            n_out.top_value = r_out.top_value;
        end

        w_depth_ext       = {{DEPTH_OUT_W{1'b0}}, n_depth};
        n_out.stack_depth = w_depth_ext[DEPTH_OUT_W-1:0];
        n_out.top_valid   = (n_depth != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
        r_neg <= n_neg;
    end

    // row of stack cells, cell 0 is the top
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_up, w_down;
        t_shift            w_sh;
        if (g == 0) begin : g_top
            assign w_up = w_load;
            assign w_sh = w_shift0;
        end else begin : g_mid
            assign w_up = w_cell[g-1];
            assign w_sh = w_shift_rest;
        end
        if (g == STACK_DEPTH - 1) begin : g_last
            assign w_down = w_cell[g];
        end else begin : g_inner
            assign w_down = w_cell[g+1];
        end
        rpnsc_cell u_cell (
            .i_clk       (i_clk),
            .i_shift     (w_sh),
            .i_from_up   (w_up),
            .i_from_down (w_down),
            .o_value     (w_cell[g])
        );
    end

    rpnsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    // no beat is taken while a divide is running
    a_no_accept_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !o_in_ready)
        else $error("input accepted during divide");

    // depth never goes past the number of cells
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(STACK_DEPTH))
        else $error("stack depth out of range");

    // divider finishes only when the control is waiting for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV))
        else $error("divider done outside divide state");

    // a divide always leaves the output register free for its result
    a_div_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !r_out_valid)
        else $error("output busy during divide");
`endif

endmodule

`default_nettype wire
